// File: design/anbx_pkg.sv
// Package for the Annex B NAL splitter: result type, sticky flag type, classification helpers.
`default_nettype none
package anbx_pkg;

  localparam int unsigned BUFFER_ADDR_BITS_DEF = 20;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned LENGTH_W = 21;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_VPS   = 2'd1;
  localparam logic [1:0] KIND_SPS   = 2'd2;
  localparam logic [1:0] KIND_PPS   = 2'd3;

  localparam logic MODE_H264 = 1'b0;
  localparam logic MODE_H265 = 1'b1;

  localparam logic [5:0] H264_SPS = 6'd7;
  localparam logic [5:0] H264_PPS = 6'd8;
  localparam logic [5:0] H265_VPS = 6'd32;
  localparam logic [5:0] H265_SPS = 6'd33;
  localparam logic [5:0] H265_PPS = 6'd34;

  typedef struct packed {
    logic       last_of_run;
    logic       first_forward;
    logic       forward;
    logic [1:0] param_kind;
    logic [5:0] nal_type;
    logic [2:0] start_code_len;
    logic [LENGTH_W-1:0] nal_length;
    logic [OFFSET_W-1:0] nal_offset;
  } res_t;

  typedef struct packed {
    logic sps_seen;
    logic pps_seen;
    logic ready;
    logic header_sent;
  } sticky_t;

  function automatic logic [1:0] kind_of(input logic mode, input logic [5:0] t);
    logic [1:0] k;
    k = KIND_OTHER;
    if (mode == MODE_H264) begin
      if (t == H264_SPS) k = KIND_SPS;
      else if (t == H264_PPS) k = KIND_PPS;
    end else begin
      if (t == H265_VPS) k = KIND_VPS;
      else if (t == H265_SPS) k = KIND_SPS;
      else if (t == H265_PPS) k = KIND_PPS;
    end
    return k;
  endfunction

  function automatic logic [5:0] header_type(input logic mode, input logic [7:0] b);
    logic [5:0] t;
    if (mode == MODE_H264) t = {1'b0, b[4:0]};
    else t = b[6:1];
    return t;
  endfunction

  // sticky flag update done when one NAL closes
  function automatic sticky_t sticky_step(input sticky_t s, input logic [1:0] kind);
    sticky_t n;
    n = s;
    if (!s.ready) begin
      if (kind == KIND_SPS) n.sps_seen = 1'b1;
      if (kind == KIND_PPS) n.pps_seen = 1'b1;
    end
    if (n.sps_seen && n.pps_seen) n.ready = 1'b1;
    if (n.ready) n.header_sent = 1'b1;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: design/anbx_core.sv
// Start code scanner and NAL classifier: per-byte state update and result build.
`default_nettype none
module anbx_core #(
  parameter int unsigned BUFFER_ADDR_BITS = anbx_pkg::BUFFER_ADDR_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           accept,
  input  wire logic [7:0]     byte_value,
  input  wire logic           last_byte,
  output anbx_pkg::res_t      res0,
  output anbx_pkg::res_t      res1,
  output logic [1:0]          push_n
);

  localparam int unsigned A = BUFFER_ADDR_BITS;

  logic         mode_r;
  logic [1:0]   zero_run_r, zero_run_nxt;
  logic         code_pending_r, code_pending_nxt;
  logic [2:0]   pcl_r, pcl_nxt;
  logic         inside_r, inside_nxt;
  logic [A-1:0] begin_r, begin_nxt;
  logic [2:0]   ncl_r, ncl_nxt;
  logic [5:0]   htype_r, htype_nxt;
  logic [A-1:0] pos_r, pos_nxt;
  anbx_pkg::sticky_t sticky_r, sticky_nxt;

  anbx_pkg::sticky_t s0;
  anbx_pkg::res_t    e0, e1;
  logic              e0_v, e1_v;
  logic [1:0]        k0, k1;
  logic [A-1:0]      len0, len1;
  logic [31:0]       w_off0, w_off1, w_len0, w_len1;

  always_comb begin
    zero_run_nxt     = zero_run_r;
    code_pending_nxt = code_pending_r;
    pcl_nxt          = pcl_r;
    inside_nxt       = inside_r;
    begin_nxt        = begin_r;
    ncl_nxt          = ncl_r;
    htype_nxt        = htype_r;
    pos_nxt          = pos_r;
    s0               = sticky_r;
    sticky_nxt       = sticky_r;
    e0_v = 1'b0;
    e1_v = 1'b0;
    k0   = anbx_pkg::kind_of(mode_r, htype_r);
    len0 = pos_r - A'(pcl_r) - begin_r;
    e0   = '0;
    e1   = '0;

    // NAL closed by the byte after a start code
    if (code_pending_r) begin
      if (inside_r) begin
        e0_v = 1'b1;
        s0   = anbx_pkg::sticky_step(sticky_r, k0);
      end
      inside_nxt       = 1'b1;
      begin_nxt        = pos_r;
      ncl_nxt          = pcl_r;
      htype_nxt        = anbx_pkg::header_type(mode_r, byte_value);
      code_pending_nxt = 1'b0;
    end
    w_off0 = 32'(begin_r);
    w_len0 = 32'(len0);
    e0.nal_offset     = w_off0[anbx_pkg::OFFSET_W-1:0];
    e0.nal_length     = w_len0[anbx_pkg::LENGTH_W-1:0];
    e0.start_code_len = ncl_r;
    e0.nal_type       = htype_r;
    e0.param_kind     = k0;
    e0.forward        = s0.ready;
    e0.first_forward  = s0.header_sent & ~sticky_r.header_sent;
    e0.last_of_run    = 1'b0;
    sticky_nxt = s0;

    if (byte_value == 8'd1 && zero_run_r >= 2'd2) begin
      code_pending_nxt = 1'b1;
      pcl_nxt          = (zero_run_r == 2'd3) ? 3'd4 : 3'd3;
      zero_run_nxt     = 2'd0;
    end else if (byte_value == 8'd0) begin
      if (zero_run_r != 2'd3) zero_run_nxt = zero_run_r + 2'd1;
    end else begin
      zero_run_nxt = 2'd0;
    end

    // buffer end closes the open NAL
    k1   = anbx_pkg::kind_of(mode_r, htype_nxt);
    len1 = pos_r + A'(1) - begin_nxt;
    if (last_byte) begin
      if (inside_nxt) begin
        e1_v       = 1'b1;
        sticky_nxt = anbx_pkg::sticky_step(s0, k1);
      end
      zero_run_nxt     = 2'd0;
      code_pending_nxt = 1'b0;
      pcl_nxt          = 3'd0;
      inside_nxt       = 1'b0;
      pos_nxt          = '0;
    end else begin
      pos_nxt = pos_r + A'(1);
    end
    w_off1 = 32'(begin_nxt);
    w_len1 = 32'(len1);
    e1.nal_offset     = w_off1[anbx_pkg::OFFSET_W-1:0];
    e1.nal_length     = w_len1[anbx_pkg::LENGTH_W-1:0];
    e1.start_code_len = ncl_nxt;
    e1.nal_type       = htype_nxt;
    e1.param_kind     = k1;
    e1.forward        = sticky_nxt.ready;
    e1.first_forward  = sticky_nxt.header_sent & ~s0.header_sent;
    e1.last_of_run    = 1'b1;

    if (e0_v) e0.last_of_run = ~e1_v;
  end

  always_comb begin
    res1 = e1;
    if (e0_v) begin
      res0 = e0;
    end else begin
      res0 = e1;
    end
    if (!accept) push_n = 2'd0;
    else push_n = {1'b0, e0_v} + {1'b0, e1_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= anbx_pkg::MODE_H264;
      zero_run_r     <= '0;
      code_pending_r <= 1'b0;
      pcl_r          <= '0;
      inside_r       <= 1'b0;
      begin_r        <= '0;
      ncl_r          <= '0;
      htype_r        <= '0;
      pos_r          <= '0;
      sticky_r       <= '0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (accept) begin
        zero_run_r     <= zero_run_nxt;
        code_pending_r <= code_pending_nxt;
        pcl_r          <= pcl_nxt;
        inside_r       <= inside_nxt;
        begin_r        <= begin_nxt;
        ncl_r          <= ncl_nxt;
        htype_r        <= htype_nxt;
        pos_r          <= pos_nxt;
        sticky_r       <= sticky_nxt;
      end
    end
  end

  a_pending_len: assert property (@(posedge clk) disable iff (!rst_n)
    code_pending_r |-> (pcl_r == 3'd3 || pcl_r == 3'd4))
    else $error("pending start code length out of range");

  a_nal_len: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r |-> (ncl_r == 3'd3 || ncl_r == 3'd4))
    else $error("open NAL start code length out of range");

  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r.ready |=> sticky_r.ready)
    else $error("ready flag dropped");

  a_header_after_ready: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r.header_sent |-> sticky_r.ready)
    else $error("header sent before ready");

endmodule
`default_nettype wire

// File: design/anbx_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while q_ready is high.
`default_nettype none
module anbx_fifo (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire anbx_pkg::res_t d0,
  input  wire anbx_pkg::res_t d1,
  input  wire logic [1:0] push_n,
  output logic           room2,
  output logic           q_valid,
  input  wire logic      q_ready,
  output anbx_pkg::res_t q
);

  localparam int unsigned PW = anbx_pkg::FIFO_PTR_W;
  localparam int unsigned CW = anbx_pkg::FIFO_CNT_W;

  anbx_pkg::res_t mem [anbx_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           pop;

  assign q_valid = (cnt_r != '0);
  assign pop     = q_valid & q_ready;
  assign room2   = (cnt_r <= CW'(anbx_pkg::FIFO_DEPTH - 2));
  assign q       = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r + PW'(push_n);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr_r] <= d0;
    if (push_n == 2'd2) mem[wr_r + PW'(1)] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(anbx_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

endmodule
`default_nettype wire

// File: design/annexb_nal_splitter_classifier.sv
// Annex B NAL splitter: results are registered in a 4-entry result queue before out_tdata.
// Throughput one byte per cycle while in_tready is high; out side moves one result per
// cycle while out_tready is high; a byte that closes two NALs pushes two results into the queue.
// in_tready drops while the queue has fewer than two free entries.
// rst_n (sync, active low) clears parser state, sticky flags, queue and codec_mode (H.264).
`default_nettype none
module annexb_nal_splitter_classifier #(
  parameter int unsigned BUFFER_ADDR_BITS = anbx_pkg::BUFFER_ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // codec_mode
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // byte_value[7:0]
  input  wire logic        in_tlast,      // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // nal_offset[19:0], nal_length[40:20], start_code_len[43:41], nal_type[49:44],
  // param_kind[51:50], forward[52], first_forward[53], zero pad[55:54]
  output logic [55:0]      out_tdata,
  output logic             out_tlast      // last_of_run
);

  anbx_pkg::res_t r0, r1, q;
  logic [1:0]     push_n;
  logic           room2;
  logic           accept;

  assign in_tready = room2;
  assign accept    = in_tvalid & room2;

  anbx_core #(.BUFFER_ADDR_BITS(BUFFER_ADDR_BITS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .byte_value  (in_tdata),
    .last_byte   (in_tlast),
    .res0        (r0),
    .res1        (r1),
    .push_n      (push_n)
  );

  anbx_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .d0      (r0),
    .d1      (r1),
    .push_n  (push_n),
    .room2   (room2),
    .q_valid (out_tvalid),
    .q_ready (out_tready),
    .q       (q)
  );

  assign out_tdata = {2'b00, q.first_forward, q.forward, q.param_kind, q.nal_type,
                      q.start_code_len, q.nal_length, q.nal_offset};
  assign out_tlast = q.last_of_run;

endmodule
`default_nettype wire
